[rtl/core/dcbd_pkg.sv]
package dcbd_pkg;

   localparam int ScoreW     = 17;
   localparam int LogW       = 24;
   localparam int SizeW      = 31;
   localparam int GridW      = 11;
   localparam int GridLimit  = 256;
   localparam logic [ScoreW-1:0] ThreshReset = 17'd52429;
   localparam logic [ScoreW-1:0] ScoreOne    = 17'd65536;
   localparam logic [1:0]  LevelUnused = 2'd3;
   localparam logic [1:0]  LevelTop    = 2'd2;

   // log2(e) in Q.16
   localparam logic [18:0] Log2eQ16 = 19'd94548;

   // Exponential: one product stage, one stage per fraction bit, one shift stage
   localparam int ExpSteps = 16;
   localparam int ExpLat   = ExpSteps + 2;

   // Square root: one product stage, then digit stages
   localparam int SqrtDigits   = 17;
   localparam int SqrtPerStage = 6;
   localparam int SqrtStages   = (SqrtDigits + SqrtPerStage - 1) / SqrtPerStage;
   localparam int SqrtLat      = SqrtStages + 1;

   typedef struct packed {
      logic signed [31:0]     class_score;
      logic signed [31:0]     object_score;
      logic signed [LogW-1:0] offset_x;
      logic signed [LogW-1:0] offset_y;
      logic signed [LogW-1:0] log_width;
      logic signed [LogW-1:0] log_height;
      logic [7:0]             grid_column;
      logic [7:0]             grid_row;
      logic [1:0]             level;
   } req_item_type;

   typedef struct packed {
      logic                status;
      logic [ScoreW-1:0]   fused_score;
      logic signed [31:0]  box_left;
      logic signed [31:0]  box_top;
      logic [SizeW-1:0]    box_width;
      logic [SizeW-1:0]    box_height;
   } rsp_item_type;

   typedef logic [ExpSteps:1][30:0] pow_table_type;

   // floor(sqrt(v)) for elaboration only
   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   // Entry j holds 2^(2^-j) in Q.30: T[0] = 2^31, T[j] = isqrt(T[j-1] * 2^30)
   function automatic pow_table_type pow_table_build();
      pow_table_type   tab;
      longint unsigned t;
      t = 64'd1 << 31;
      for (int j = 1; j <= ExpSteps; j++) begin
         t = root_floor(t << 30);
         tab[j] = t[30:0];
      end
      return tab;
   endfunction

   localparam pow_table_type PowTable = pow_table_build();

endpackage

[rtl/core/dcbd_delay.sv]
module dcbd_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] data_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            data_ff[i] <= data_ff[i-1];
         end
      end
   end

   assign dout = data_ff[DEPTH-1];

endmodule

[rtl/core/dcbd_sqrt.sv]
module dcbd_sqrt (
   input  logic                        clock,
   input  logic                        adv,
   input  logic signed [31:0]          class_score,
   input  logic signed [31:0]          object_score,
   output logic [dcbd_pkg::ScoreW-1:0] fused_out
);

   import dcbd_pkg::*;

   typedef struct packed {
      logic [33:0] rad;
      logic [18:0] rem;
      logic [16:0] root;
   } sqrt_lane_type;

   sqrt_lane_type lane_ff [SqrtStages+1];
   sqrt_lane_type lane_in [SqrtStages+1];

   function automatic logic [ScoreW-1:0] clamp_score(input logic signed [31:0] v);
      logic [ScoreW-1:0] r;
      if (v[31]) r = '0;
      else if (v > $signed({15'b0, ScoreOne})) r = ScoreOne;
      else r = v[ScoreW-1:0];
      return r;
   endfunction

   always_comb begin
      sqrt_lane_type w;
      logic [20:0]   acc;
      logic [20:0]   trial;
      lane_in[0].rad  = {17'b0, clamp_score(class_score)} * {17'b0, clamp_score(object_score)};
      lane_in[0].rem  = '0;
      lane_in[0].root = '0;
      for (int st = 1; st <= SqrtStages; st++) begin
         w = lane_ff[st-1];
         for (int n = 0; n < SqrtPerStage; n++) begin
            if ((st - 1) * SqrtPerStage + n < SqrtDigits) begin
               acc   = {w.rem, w.rad[33:32]};
               trial = {2'b0, w.root, 2'b01};
               if (acc >= trial) begin
                  w.rem  = 19'(acc - trial);
                  w.root = {w.root[15:0], 1'b1};
               end else begin
                  w.rem  = acc[18:0];
                  w.root = {w.root[15:0], 1'b0};
               end
               w.rad = {w.rad[31:0], 2'b00};
            end
         end
         lane_in[st] = w;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int st = 0; st <= SqrtStages; st++) begin
            lane_ff[st] <= lane_in[st];
         end
      end
   end

   assign fused_out = lane_ff[SqrtStages].root;

endmodule

[rtl/core/dcbd_exp.sv]
module dcbd_exp (
   input  logic                             clock,
   input  logic                             adv,
   input  logic signed [dcbd_pkg::LogW-1:0] log_in,
   input  logic [2:0]                       scale_in,
   output logic [dcbd_pkg::SizeW-1:0]       size_out,
   output logic                             bad_out
);

   import dcbd_pkg::*;

   typedef struct packed {
      logic signed [10:0] k;
      logic [15:0]        f;
      logic [2:0]         scale;
      logic [30:0]        m;
   } exp_lane_type;

   exp_lane_type       lane_ff [ExpSteps+1];
   exp_lane_type       lane_in [ExpSteps+1];
   logic signed [42:0] prod;
   logic [SizeW-1:0]   size_ff;
   logic [SizeW-1:0]   size_in;
   logic               bad_ff;
   logic               bad_in;

   // y = x * log2(e); k is the integer part, f the fraction
   assign prod = log_in * $signed(Log2eQ16);

   always_comb begin
      logic [61:0] mp;
      lane_in[0].k     = prod[42:32];
      lane_in[0].f     = prod[31:16];
      lane_in[0].scale = scale_in;
      lane_in[0].m     = 31'h4000_0000;
      for (int s = 1; s <= ExpSteps; s++) begin
         lane_in[s] = lane_ff[s-1];
         mp = {31'b0, lane_ff[s-1].m} * {31'b0, PowTable[s]};
         if (lane_ff[s-1].f[ExpSteps-s]) lane_in[s].m = mp[60:30];
      end
   end

   // Scale by 2^(k + scale - 22): saturate on overflow, flag a zero size
   always_comb begin
      logic signed [11:0] sh;
      logic [11:0]        nsh;
      logic [61:0]        wide;
      logic               sat;
      exp_lane_type       ln;
      ln   = lane_ff[ExpSteps];
      sh   = {ln.k[10], ln.k} + $signed({9'b0, ln.scale}) - 12'sd22;
      nsh  = 12'(-sh);
      wide = {31'b0, ln.m} << sh[4:0];
      sat  = 1'b0;
      size_in = '0;
      if (!sh[11]) begin
         if (sh > 12'sd31 || (|wide[61:31])) sat = 1'b1;
         else size_in = wide[30:0];
      end else if (nsh < 12'd31) begin
         size_in = ln.m >> nsh[4:0];
      end
      if (sat) size_in = '1;
      bad_in = sat || (size_in == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s <= ExpSteps; s++) begin
            lane_ff[s] <= lane_in[s];
         end
         size_ff <= size_in;
         bad_ff  <= bad_in;
      end
   end

   assign size_out = size_ff;
   assign bad_out  = bad_ff;

endmodule

[rtl/core/detection_cell_box_decode.sv]
// Channel   Ports                            Direction  Payload
// req       req_valid  req_ready  req_item   in         one grid cell
// rsp       rsp_valid  rsp_ready  rsp_item   out        one kept box
// csr       csr_wen    csr_wdata             in         score threshold, Q1.16
//
// One item enters every cycle while the output register is free or taken.
// The pipeline depth is set by the exponential: one product stage, sixteen
// table-multiply stages (one per fraction bit) and one scaling stage,
// followed by the edge stage in the output register.
// Reset clears the valid bits and loads the threshold with 0.8.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage, so no item is lost or repeated.
module detection_cell_box_decode (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  dcbd_pkg::req_item_type        req_item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output dcbd_pkg::rsp_item_type        rsp_item,
   input  logic                          csr_wen,
   input  logic [dcbd_pkg::ScoreW-1:0]   csr_wdata
);

   import dcbd_pkg::*;

   // Cell data that rides alongside the exponential
   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic               bad;
   } meta_type;

   typedef struct packed {
      logic [ScoreW-1:0] fused;
      logic              keep;
   } score_type;

   logic              adv;
   logic [ScoreW-1:0] thresh_ff;
   logic [ScoreW-1:0] thresh_in;
   logic [ExpLat-1:0] vld_ff;
   logic [ExpLat-1:0] vld_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_item_type      rsp_item_ff;
   rsp_item_type      rsp_item_in;

   logic              lvl_bad;
   logic              grid_bad;
   logic [1:0]        lvl;
   logic [2:0]        scale;
   logic signed [25:0] base_x;
   logic signed [25:0] base_y;
   meta_type          meta_in;
   meta_type          meta_out;
   logic [ScoreW-1:0] fused;
   score_type         score_in;
   score_type         score_out;
   logic [SizeW-1:0]  width;
   logic [SizeW-1:0]  height;
   logic              width_bad;
   logic              height_bad;
   logic signed [39:0] left_diff;
   logic signed [39:0] top_diff;

   // Advance everything when the output register is free or being taken
   assign adv       = !rsp_valid_ff || rsp_ready;
   // Hold off the input while reset is applied
   assign req_ready = adv && !reset;

   assign thresh_in = csr_wen ? csr_wdata : thresh_ff;

   // Unused level decodes as stride 32 and is flagged
   assign lvl_bad  = (req_item.level == LevelUnused);
   assign lvl      = lvl_bad ? LevelTop : req_item.level;
   assign scale    = 3'd3 + {1'b0, lvl};
   assign grid_bad = ({3'b0, req_item.grid_column} >= GridW'(GridLimit))
                  || ({3'b0, req_item.grid_row} >= GridW'(GridLimit));

   // Centre in Q.16 pixels: (cell + offset) * stride
   assign base_x = $signed({2'b00, req_item.grid_column, 16'h0000})
                 + {{2{req_item.offset_x[LogW-1]}}, req_item.offset_x};
   assign base_y = $signed({2'b00, req_item.grid_row, 16'h0000})
                 + {{2{req_item.offset_y[LogW-1]}}, req_item.offset_y};

   assign meta_in.cx  = {{6{base_x[25]}}, base_x} << scale;
   assign meta_in.cy  = {{6{base_y[25]}}, base_y} << scale;
   assign meta_in.bad = lvl_bad || grid_bad;

   dcbd_delay #(
      .WIDTH ($bits(meta_type)),
      .DEPTH (ExpLat)
   ) u_meta_delay (
      .clock (clock),
      .adv   (adv),
      .din   (meta_in),
      .dout  (meta_out)
   );

   dcbd_sqrt u_sqrt (
      .clock        (clock),
      .adv          (adv),
      .class_score  (req_item.class_score),
      .object_score (req_item.object_score),
      .fused_out    (fused)
   );

   // Decide keep/drop as soon as the score is known, then hold it until the box is ready
   assign score_in.fused = fused;
   assign score_in.keep  = (fused >= thresh_ff);

   dcbd_delay #(
      .WIDTH ($bits(score_type)),
      .DEPTH (ExpLat - SqrtLat)
   ) u_score_delay (
      .clock (clock),
      .adv   (adv),
      .din   (score_in),
      .dout  (score_out)
   );

   dcbd_exp u_exp_width (
      .clock    (clock),
      .adv      (adv),
      .log_in   (req_item.log_width),
      .scale_in (scale),
      .size_out (width),
      .bad_out  (width_bad)
   );

   dcbd_exp u_exp_height (
      .clock    (clock),
      .adv      (adv),
      .log_in   (req_item.log_height),
      .scale_in (scale),
      .size_out (height),
      .bad_out  (height_bad)
   );

   // Edge = floor((centre - size/2) in Q.8); the shifted difference always fits 32 bits
   assign left_diff = {{8{meta_out.cx[31]}}, meta_out.cx} - $signed({2'b00, width, 7'b0});
   assign top_diff  = {{8{meta_out.cy[31]}}, meta_out.cy} - $signed({2'b00, height, 7'b0});

   assign vld_in       = {vld_ff[ExpLat-2:0], req_valid && req_ready};
   assign rsp_valid_in = vld_ff[ExpLat-1] && score_out.keep;

   always_comb begin
      rsp_item_in.status      = meta_out.bad || width_bad || height_bad;
      rsp_item_in.fused_score = score_out.fused;
      rsp_item_in.box_left    = left_diff[39:8];
      rsp_item_in.box_top     = top_diff[39:8];
      rsp_item_in.box_width   = width;
      rsp_item_in.box_height  = height;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= ThreshReset;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thresh_ff <= thresh_in;
         if (adv) begin
            vld_ff       <= vld_in;
            rsp_valid_ff <= rsp_valid_in;
         end
      end
   end

   // Hold the result payload while the consumer stalls
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
